>>> hdl/rdi_pkg.sv
package rdi_pkg;

	typedef enum logic [2:0] {
		REG_CENTER_X       = 3'd0,
		REG_CENTER_Y       = 3'd1,
		REG_CENTER_Z       = 3'd2,
		REG_NORMAL_X       = 3'd3,
		REG_NORMAL_Y       = 3'd4,
		REG_NORMAL_Z       = 3'd5,
		REG_RADIUS_SQUARED = 3'd6,
		REG_CAST_SHADOWS   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] direction_x;
		logic signed [31:0] direction_y;
		logic signed [31:0] direction_z;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic        [30:0] hit_distance;
		logic signed [31:0] hit_x;
		logic signed [31:0] hit_y;
		logic signed [31:0] hit_z;
	} result_t;

	typedef struct packed {
		logic             miss;
		logic [2:0][31:0] org;
		logic [2:0][31:0] dir;
	} ctx_t;

	localparam logic [15:0] NORMAL_Y_RESET = 16'sd16384;
	localparam logic [47:0] RADIUS_SQUARED_RESET = 48'd65536;

endpackage

>>> hdl/ray_disk_intersection.sv
// Ray against disk test, fully pipelined.
// Structure: 14 arithmetic stages plus a 31-stage restoring divider that
// resolves one bit of t per stage.
// Throughput: one ray per cycle; the whole pipeline holds while a result waits.
// Reset: arst_n clears all valid bits and loads the register reset values.
module ray_disk_intersection #(
	parameter int EPSILON_UNITS = 7,
	parameter int FRACTION_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ray_valid,
	output logic             ray_ready,
	input  rdi_pkg::ray_t    ray,
	output logic             result_valid,
	input  logic             result_ready,
	output rdi_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [5:0]       paddr,
	input  logic [63:0]      pwdata,
	output logic [63:0]      prdata,
	output logic             pready
);

	localparam int F   = FRACTION_BITS;
	localparam int IW  = 31 - F;
	localparam int NMW = 51;
	localparam int ND  = 31;
	localparam int ML  = 24 + (F + 1) / 2;
	localparam int HW  = ML - 16;
	localparam int CW  = 2 * ML + 2;

	logic signed [31:0] cen_q [3];
	logic signed [15:0] nrm_q [3];
	logic        [47:0] rsq_q;
	logic               shd_q;

	logic en;
	rdi_pkg::reg_idx_t ridx;

	assign pready = 1'b1;
	assign ridx = rdi_pkg::reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cen_q[0] <= '0;
			cen_q[1] <= '0;
			cen_q[2] <= '0;
			nrm_q[0] <= '0;
			nrm_q[1] <= rdi_pkg::NORMAL_Y_RESET;
			nrm_q[2] <= '0;
			rsq_q <= rdi_pkg::RADIUS_SQUARED_RESET;
			shd_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				rdi_pkg::REG_CENTER_X:       cen_q[0] <= pwdata[31:0];
				rdi_pkg::REG_CENTER_Y:       cen_q[1] <= pwdata[31:0];
				rdi_pkg::REG_CENTER_Z:       cen_q[2] <= pwdata[31:0];
				rdi_pkg::REG_NORMAL_X:       nrm_q[0] <= pwdata[15:0];
				rdi_pkg::REG_NORMAL_Y:       nrm_q[1] <= pwdata[15:0];
				rdi_pkg::REG_NORMAL_Z:       nrm_q[2] <= pwdata[15:0];
				rdi_pkg::REG_RADIUS_SQUARED: rsq_q <= pwdata[47:0];
				rdi_pkg::REG_CAST_SHADOWS:   shd_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			rdi_pkg::REG_CENTER_X:       prdata = {32'd0, cen_q[0]};
			rdi_pkg::REG_CENTER_Y:       prdata = {32'd0, cen_q[1]};
			rdi_pkg::REG_CENTER_Z:       prdata = {32'd0, cen_q[2]};
			rdi_pkg::REG_NORMAL_X:       prdata = {48'd0, nrm_q[0]};
			rdi_pkg::REG_NORMAL_Y:       prdata = {48'd0, nrm_q[1]};
			rdi_pkg::REG_NORMAL_Z:       prdata = {48'd0, nrm_q[2]};
			rdi_pkg::REG_RADIUS_SQUARED: prdata = {16'd0, rsq_q};
			rdi_pkg::REG_CAST_SHADOWS:   prdata = {63'd0, shd_q};
			default:                     prdata = '0;
		endcase
	end

	// stage registers
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13, vld_s14;
	rdi_pkg::ray_t in_s1;
	rdi_pkg::ctx_t ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s7, ctx_s8;
	logic signed [32:0] diff_s2 [3];
	logic signed [48:0] np_s3 [3];
	logic signed [47:0] dp_s3 [3];
	logic signed [50:0] num_s4;
	logic signed [49:0] den_s4;
	logic [NMW-1:0] nmag_s5, dmag_s5;

	logic           div_vld_s  [ND+1];
	rdi_pkg::ctx_t  div_ctx_s  [ND+1];
	logic [NMW-1:0] div_rem_s  [ND+1];
	logic [NMW-1:0] div_dmag_s [ND+1];
	logic [30:0]    div_q_s    [ND+1];

	logic signed [63:0] prod_s7 [3];
	logic signed [64:0] pt_s8 [3];
	logic signed [65:0] delta_s9 [3];
	logic [HW-1:0] h_s10 [3];
	logic [15:0]   l_s10 [3];
	logic [2*HW-1:0] hh_s11 [3];
	logic [ML-1:0]   hl_s11 [3];
	logic [31:0]     ll_s11 [3];
	logic [CW-1:0] sq_s12 [3];
	logic [CW-1:0] sum_s13;
	logic [30:0] t_s7, t_s8, t_s9, t_s10, t_s11, t_s12, t_s13;
	logic [2:0][31:0] p_s9, p_s10, p_s11, p_s12, p_s13;
	logic miss_s9, miss_s10, miss_s11, miss_s12, miss_s13;
	rdi_pkg::result_t res_s14;

	logic [65:0] mag [3];

	assign en = !vld_s14 || result_ready;
	assign ray_ready = en;
	assign result_valid = vld_s14;
	assign result = res_s14;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = delta_s9[i][65] ? 66'(-delta_s9[i]) : 66'(delta_s9[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			div_vld_s[0] <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
		end else if (en) begin
			vld_s1 <= ray_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			div_vld_s[0] <= vld_s5;
			vld_s7 <= div_vld_s[ND];
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s1 <= ray;

			ctx_s2.miss <= in_s1.kind && !shd_q;
			ctx_s2.org <= {in_s1.origin_z, in_s1.origin_y, in_s1.origin_x};
			ctx_s2.dir <= {in_s1.direction_z, in_s1.direction_y, in_s1.direction_x};
			diff_s2[0] <= 33'(cen_q[0]) - 33'(in_s1.origin_x);
			diff_s2[1] <= 33'(cen_q[1]) - 33'(in_s1.origin_y);
			diff_s2[2] <= 33'(cen_q[2]) - 33'(in_s1.origin_z);

			ctx_s3 <= ctx_s2;
			for (int i = 0; i < 3; i++) begin
				np_s3[i] <= 49'(diff_s2[i]) * 49'(nrm_q[i]);
				dp_s3[i] <= 48'($signed(ctx_s2.dir[i])) * 48'(nrm_q[i]);
			end

			ctx_s4 <= ctx_s3;
			num_s4 <= 51'(np_s3[0]) + 51'(np_s3[1]) + 51'(np_s3[2]);
			den_s4 <= 50'(dp_s3[0]) + 50'(dp_s3[1]) + 50'(dp_s3[2]);

			ctx_s5.org <= ctx_s4.org;
			ctx_s5.dir <= ctx_s4.dir;
			ctx_s5.miss <= ctx_s4.miss || (num_s4 == '0) || (den_s4 == '0)
				|| (num_s4[50] != den_s4[49]);
			nmag_s5 <= num_s4[50] ? NMW'(-num_s4) : NMW'(num_s4);
			dmag_s5 <= {1'b0, (den_s4[49] ? 50'(-den_s4) : 50'(den_s4))};

			div_ctx_s[0].org <= ctx_s5.org;
			div_ctx_s[0].dir <= ctx_s5.dir;
			div_ctx_s[0].miss <= ctx_s5.miss || ((nmag_s5 >> IW) >= dmag_s5);
			div_rem_s[0] <= nmag_s5 >> IW;
			div_dmag_s[0] <= dmag_s5;
			div_q_s[0] <= {nmag_s5[IW-1:0], F'(0)};

			ctx_s7.org <= div_ctx_s[ND].org;
			ctx_s7.dir <= div_ctx_s[ND].dir;
			ctx_s7.miss <= div_ctx_s[ND].miss || (div_q_s[ND] <= 31'(EPSILON_UNITS));
			t_s7 <= div_q_s[ND];
			for (int i = 0; i < 3; i++) begin
				prod_s7[i] <= 64'($signed({1'b0, div_q_s[ND]}))
					* 64'($signed(div_ctx_s[ND].dir[i]));
			end

			ctx_s8 <= ctx_s7;
			t_s8 <= t_s7;
			for (int i = 0; i < 3; i++) begin
				pt_s8[i] <= 65'($signed(ctx_s7.org[i])) + 65'(prod_s7[i] >>> F);
			end

			miss_s9 <= ctx_s8.miss;
			t_s9 <= t_s8;
			for (int i = 0; i < 3; i++) begin
				delta_s9[i] <= 66'(pt_s8[i]) - 66'(cen_q[i]);
				if (pt_s8[i] > 65'sd2147483647) begin
					p_s9[i] <= 32'h7fffffff;
				end else if (pt_s8[i] < -65'sd2147483648) begin
					p_s9[i] <= 32'h80000000;
				end else begin
					p_s9[i] <= pt_s8[i][31:0];
				end
			end

			t_s10 <= t_s9;
			p_s10 <= p_s9;
			miss_s10 <= miss_s9 || (mag[0][65:ML] != '0) || (mag[1][65:ML] != '0)
				|| (mag[2][65:ML] != '0);
			for (int i = 0; i < 3; i++) begin
				h_s10[i] <= mag[i][ML-1:16];
				l_s10[i] <= mag[i][15:0];
			end

			t_s11 <= t_s10;
			p_s11 <= p_s10;
			miss_s11 <= miss_s10;
			for (int i = 0; i < 3; i++) begin
				hh_s11[i] <= (2*HW)'(h_s10[i]) * (2*HW)'(h_s10[i]);
				hl_s11[i] <= ML'(h_s10[i]) * ML'(l_s10[i]);
				ll_s11[i] <= 32'(l_s10[i]) * 32'(l_s10[i]);
			end

			t_s12 <= t_s11;
			p_s12 <= p_s11;
			miss_s12 <= miss_s11;
			for (int i = 0; i < 3; i++) begin
				sq_s12[i] <= (CW'(hh_s11[i]) << 32) + (CW'(hl_s11[i]) << 17)
					+ CW'(ll_s11[i]);
			end

			t_s13 <= t_s12;
			p_s13 <= p_s12;
			miss_s13 <= miss_s12;
			sum_s13 <= sq_s12[0] + sq_s12[1] + sq_s12[2];

			if (!miss_s13 && (sum_s13 < (CW'(rsq_q) << F))) begin
				res_s14.hit <= 1'b1;
				res_s14.hit_distance <= t_s13;
				res_s14.hit_x <= p_s13[0];
				res_s14.hit_y <= p_s13[1];
				res_s14.hit_z <= p_s13[2];
			end else begin
				res_s14 <= '0;
			end
		end
	end

	for (genvar k = 1; k <= ND; k++) begin : g_div
		logic [NMW:0] rem2;
		logic         ge;

		assign rem2 = {div_rem_s[k-1], div_q_s[k-1][30]};
		assign ge = rem2 >= {1'b0, div_dmag_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k] <= 1'b0;
			end else if (en) begin
				div_vld_s[k] <= div_vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_ctx_s[k] <= div_ctx_s[k-1];
				div_dmag_s[k] <= div_dmag_s[k-1];
				div_rem_s[k] <= ge ? NMW'(rem2 - {1'b0, div_dmag_s[k-1]}) : NMW'(rem2);
				div_q_s[k] <= {div_q_s[k-1][29:0], ge};
			end
		end
	end

`ifndef ASSERT_OFF
	a_hit_beyond_eps: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.hit |-> result.hit_distance > 31'(EPSILON_UNITS))
		else $error("hit with t at or below epsilon");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.hit |-> result == '0)
		else $error("miss result not cleared");

	a_div_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(div_q_s[ND]) && $stable(div_vld_s[ND]))
		else $error("divider advanced during stall");

	a_ready_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !ray_ready)
		else $error("ray taken while result stalled");
`endif

endmodule
